>>> hdl/pfc_pkg.sv
// Package for the PID feed-forward controller: microcode types, step program and constants.
package pfc_pkg;

    // Width of the step counter; the program has exactly 2**PC_W steps.
    localparam int PC_W     = 3;
    localparam int Q_W      = 32;              // Q16.16 word width
    localparam int TS_W     = 16;              // time step width
    localparam int LIM_W    = 31;              // limit register width
    localparam int FRAC_W   = 16;              // fraction bits
    localparam int PROD_W   = 2 * Q_W;         // multiplier product width
    localparam int TERM_W   = PROD_W - FRAC_W; // product after the shift
    localparam int ACC_W    = TERM_W + 2;      // three terms plus feed-forward
    localparam int IDX_W    = 3;               // configuration index width
    localparam int IN_W     = 5 * Q_W + TS_W;  // packed input item width

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4
    } reg_idx_t;

    // Multiplier operand pair.
    typedef enum logic [1:0] {
        MUL_ERR_TS,
        MUL_P_ERR,
        MUL_D_RERR,
        MUL_I_INTEG
    } mul_sel_t;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD_FF,
        ACC_ADD_PROD
    } acc_op_t;

    // Jump condition; when it holds the counter loads the target, else it advances.
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_IN,
        COND_GI_ZERO,
        COND_OUT_BUSY
    } cond_t;

    // One control word.
    typedef struct packed {
        logic            cap;
        logic            diff;
        logic            integ;
        logic            mul_en;
        mul_sel_t        mul_sel;
        acc_op_t         acc_op;
        logic            out_en;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Step addresses.
    localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] STEP_DIFF  = 3'd1;
    localparam logic [PC_W-1:0] STEP_MTS   = 3'd2;
    localparam logic [PC_W-1:0] STEP_INTEG = 3'd3;
    localparam logic [PC_W-1:0] STEP_ADDP  = 3'd4;
    localparam logic [PC_W-1:0] STEP_ADDD  = 3'd5;
    localparam logic [PC_W-1:0] STEP_ADDI  = 3'd6;
    localparam logic [PC_W-1:0] STEP_OUT   = 3'd7;

    // Control program; the last step falls through to the first by wrap-around.
    function automatic ctrl_t ctrl_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{cap: 1'b0, diff: 1'b0, integ: 1'b0, mul_en: 1'b0, mul_sel: MUL_ERR_TS,
              acc_op: ACC_NONE, out_en: 1'b0, cond: COND_NEVER, target: STEP_WAIT};
        case (pc)
            STEP_WAIT:
            begin
                w.cap    = 1'b1;
                w.cond   = COND_NO_IN;
                w.target = STEP_WAIT;
            end
            STEP_DIFF:
            begin
                w.diff   = 1'b1;
                w.acc_op = ACC_LOAD_FF;
            end
            STEP_MTS:
            begin
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_ERR_TS;
            end
            STEP_INTEG:
            begin
                w.integ   = 1'b1;
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_P_ERR;
            end
            STEP_ADDP:
            begin
                w.acc_op  = ACC_ADD_PROD;
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_D_RERR;
            end
            STEP_ADDD:
            begin
                w.acc_op  = ACC_ADD_PROD;
                w.mul_en  = 1'b1;
                w.mul_sel = MUL_I_INTEG;
                w.cond    = COND_GI_ZERO;
                w.target  = STEP_OUT;
            end
            STEP_ADDI:
            begin
                w.acc_op = ACC_ADD_PROD;
            end
            STEP_OUT:
            begin
                w.out_en = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_OUT;
            end
            default:
            begin
                w.cond   = COND_NEVER;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/pid_feedforward_controller_core.sv
// Top level of the PID feed-forward controller: microcoded sequencer over one shared multiplier.
//
// Channel   Direction  Handshake               Payload
// s_axis    in         s_axis_tvalid/tready    tdata: measured, measured_rate, target,
//                                              target_rate, ff_term, time_step
// m_axis    out        m_axis_tvalid/tready    tdata: drive
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// An item runs from acceptance through the difference, error-times-step, integral, P, D, I
// and output steps of the eight-step control program on the one 32x32 multiplier; the I
// step is skipped when gain_i is zero. The next item is taken the cycle after the result loads.
// Reset clears the step counter, the output valid, the configuration registers and the integral.
// A stalled output holds the program at its last step; an item waiting there is delivered
// once the output register frees up. cfg_ready is always high.
module pid_feedforward_controller_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // measured[31:0], measured_rate[63:32], target[95:64], target_rate[127:96],
    // ff_term[159:128], time_step[175:160]
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // drive[31:0]
    output logic [31:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int QW = pfc_pkg::Q_W;
    localparam int FW = pfc_pkg::FRAC_W;
    localparam logic signed [QW:0] SatMax = {2'b00, {(QW-1){1'b1}}};
    localparam logic signed [QW:0] SatMin = {2'b11, {(QW-1){1'b0}}};

    // Step counter and control word
    logic [pfc_pkg::PC_W-1:0] pc_reg, pc_next;
    pfc_pkg::ctrl_t           ctrl;

    // Configuration registers
    logic signed [QW-1:0]          gain_p_reg, gain_i_reg, gain_d_reg;
    logic [pfc_pkg::LIM_W-1:0]     integral_limit_reg, output_limit_reg;

    // Captured input item
    logic signed [QW-1:0]          measured_reg, measured_rate_reg, target_reg;
    logic signed [QW-1:0]          target_rate_reg, ff_term_reg;
    logic [pfc_pkg::TS_W-1:0]      time_step_reg;

    // Datapath registers
    logic signed [QW-1:0]             err_reg, rerr_reg;
    logic signed [QW-1:0]             integral_reg, integral_next;
    logic signed [pfc_pkg::PROD_W-1:0] prod_reg;
    logic signed [pfc_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic                              out_valid_reg;
    logic [QW-1:0]                     out_data_reg;

    logic in_accept, out_free, gi_zero, take_jump;
    logic signed [QW:0]    err_wide, rerr_wide, integ_sum;
    logic signed [QW-1:0]  err_sat, rerr_sat, integ_sat, ilim_pos, ilim_neg;
    logic signed [QW-1:0]  mul_a, mul_b;
    logic signed [pfc_pkg::ACC_W-1:0] olim_pos, olim_neg;
    logic signed [QW-1:0]  drive_clamped;

    assign ctrl          = pfc_pkg::ctrl_rom(pc_reg);
    assign s_axis_tready = ctrl.cap;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign gi_zero       = (gain_i_reg == '0);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Evaluate the jump condition
    always_comb
    begin
        case (ctrl.cond)
            pfc_pkg::COND_NEVER:    take_jump = 1'b0;
            pfc_pkg::COND_NO_IN:    take_jump = !in_accept;
            pfc_pkg::COND_GI_ZERO:  take_jump = gi_zero;
            pfc_pkg::COND_OUT_BUSY: take_jump = !out_free;
            default:                take_jump = 1'b0;
        endcase
        pc_next = take_jump ? ctrl.target : pc_reg + 1'b1;
    end

    // Saturate both differences
    always_comb
    begin
        err_wide  = (QW+1)'(target_reg) - (QW+1)'(measured_reg);
        rerr_wide = (QW+1)'(target_rate_reg) - (QW+1)'(measured_rate_reg);
        if (err_wide > SatMax)
            err_sat = SatMax[QW-1:0];
        else if (err_wide < SatMin)
            err_sat = SatMin[QW-1:0];
        else
            err_sat = err_wide[QW-1:0];
        if (rerr_wide > SatMax)
            rerr_sat = SatMax[QW-1:0];
        else if (rerr_wide < SatMin)
            rerr_sat = SatMin[QW-1:0];
        else
            rerr_sat = rerr_wide[QW-1:0];
    end

    // Advance the integral by the floored increment, saturate, then clamp; a zero gain_i clears it
    always_comb
    begin
        ilim_pos  = $signed({1'b0, integral_limit_reg});
        ilim_neg  = -ilim_pos;
        integ_sum = (QW+1)'(integral_reg) + (QW+1)'($signed(prod_reg[FW+QW-1:FW]));
        if (integ_sum > SatMax)
            integ_sat = SatMax[QW-1:0];
        else if (integ_sum < SatMin)
            integ_sat = SatMin[QW-1:0];
        else
            integ_sat = integ_sum[QW-1:0];
        if (gi_zero)
            integral_next = '0;
        else if (integ_sat > ilim_pos)
            integral_next = ilim_pos;
        else if (integ_sat < ilim_neg)
            integral_next = ilim_neg;
        else
            integral_next = integ_sat;
    end

    // Select multiplier operands
    always_comb
    begin
        case (ctrl.mul_sel)
            pfc_pkg::MUL_ERR_TS:
            begin
                mul_a = err_reg;
                mul_b = $signed(QW'(time_step_reg));
            end
            pfc_pkg::MUL_P_ERR:
            begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            pfc_pkg::MUL_D_RERR:
            begin
                mul_a = gain_d_reg;
                mul_b = rerr_reg;
            end
            pfc_pkg::MUL_I_INTEG:
            begin
                mul_a = gain_i_reg;
                mul_b = integral_reg;
            end
            default:
            begin
                mul_a = err_reg;
                mul_b = err_reg;
            end
        endcase
    end

    // Accumulate floored products onto the feed-forward term
    always_comb
    begin
        case (ctrl.acc_op)
            pfc_pkg::ACC_NONE:     acc_next = acc_reg;
            pfc_pkg::ACC_LOAD_FF:  acc_next = pfc_pkg::ACC_W'(ff_term_reg);
            pfc_pkg::ACC_ADD_PROD: acc_next = acc_reg
                                       + pfc_pkg::ACC_W'($signed(prod_reg[pfc_pkg::PROD_W-1:FW]));
            default:               acc_next = acc_reg;
        endcase
    end

    // Clamp the sum to the output limit
    always_comb
    begin
        olim_pos = $signed(pfc_pkg::ACC_W'(output_limit_reg));
        olim_neg = -olim_pos;
        if (acc_reg > olim_pos)
            drive_clamped = olim_pos[QW-1:0];
        else if (acc_reg < olim_neg)
            drive_clamped = olim_neg[QW-1:0];
        else
            drive_clamped = acc_reg[QW-1:0];
    end

    // Control state, configuration and integral
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg             <= pfc_pkg::STEP_WAIT;
            out_valid_reg      <= 1'b0;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            integral_limit_reg <= '0;
            output_limit_reg   <= '0;
            integral_reg       <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (ctrl.out_en && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (ctrl.integ)
                integral_reg <= integral_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pfc_pkg::REG_GAIN_P:         gain_p_reg <= cfg_data;
                    pfc_pkg::REG_GAIN_I:         gain_i_reg <= cfg_data;
                    pfc_pkg::REG_GAIN_D:         gain_d_reg <= cfg_data;
                    pfc_pkg::REG_INTEGRAL_LIMIT:
                        integral_limit_reg <= cfg_data[pfc_pkg::LIM_W-1:0];
                    pfc_pkg::REG_OUTPUT_LIMIT:
                        output_limit_reg   <= cfg_data[pfc_pkg::LIM_W-1:0];
                    default:                     gain_p_reg <= gain_p_reg;
                endcase
            end
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            measured_reg      <= s_axis_tdata[31:0];
            measured_rate_reg <= s_axis_tdata[63:32];
            target_reg        <= s_axis_tdata[95:64];
            target_rate_reg   <= s_axis_tdata[127:96];
            ff_term_reg       <= s_axis_tdata[159:128];
            time_step_reg     <= s_axis_tdata[175:160];
        end
        if (ctrl.diff)
        begin
            err_reg  <= err_sat;
            rerr_reg <= rerr_sat;
        end
        if (ctrl.mul_en)
            prod_reg <= mul_a * mul_b;
        acc_reg <= acc_next;
        if (ctrl.out_en && out_free)
            out_data_reg <= drive_clamped;
    end

endmodule

>>> hdl/pfc_checker.sv
// Port-level checker for the PID feed-forward controller, bound to the top level.
module pfc_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [2:0]   cfg_index,
    input logic [31:0]  cfg_data
);

    logic [30:0] olim_reg;
    logic signed [32:0] drive_w, lim_w;

    // Track the output limit as written on the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            olim_reg <= '0;
        else if (cfg_valid && cfg_ready && cfg_index == 3'(pfc_pkg::REG_OUTPUT_LIMIT))
            olim_reg <= cfg_data[30:0];
    end

    assign drive_w = $signed({m_axis_tdata[31], m_axis_tdata});
    assign lim_w   = $signed({2'b00, olim_reg});

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A shown result lies within the output limit
    a_out_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (drive_w <= lim_w) && (drive_w >= -lim_w))
        else $error("drive outside output limit");

    // The block is busy right after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // A new result never appears within the cycle after an input item is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too early");

endmodule

bind pid_feedforward_controller_core pfc_checker u_pfc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

>>> bench/pfc_drive_checker.sv
// Checker for the PID feed-forward controller: predicts each drive value and compares results.
module pfc_drive_checker
    import pfc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    input  logic            s_axis_tready,
    // measured[31:0], measured_rate[63:32], target[95:64], target_rate[127:96],
    // ff_term[159:128], time_step[175:160]
    input  logic [IN_W-1:0] s_axis_tdata,
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // drive[31:0]
    input  logic [Q_W-1:0]  m_axis_tdata,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]  cfg_data,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One sample as it sits in tdata, highest field first.
    typedef struct packed {
        logic        [TS_W-1:0] time_step;
        logic signed [Q_W-1:0]  ff_term;
        logic signed [Q_W-1:0]  target_rate;
        logic signed [Q_W-1:0]  target;
        logic signed [Q_W-1:0]  measured_rate;
        logic signed [Q_W-1:0]  measured;
    } sample_t;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    // Shadow of the register file and the kept integral.
    longint kp;
    longint ki;
    longint kd;
    longint integ_bound;
    longint drive_bound;
    longint integ_acc;

    // Drive values still owed by the block, oldest first.
    logic [Q_W-1:0] drive_q[$];

    function automatic longint sat_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    function automatic longint clamp_to(input longint v, input longint bound);
        if (v > bound)
            return bound;
        if (v < -bound)
            return -bound;
        return v;
    endfunction

    // Advance the integral and form the clamped drive for one sample.
    function automatic logic [Q_W-1:0] next_drive(input sample_t s);
        longint err;
        longint rate_err;
        longint total;
        err      = sat_word(longint'(s.target) - longint'(s.measured));
        rate_err = sat_word(longint'(s.target_rate) - longint'(s.measured_rate));
        if (ki != 0)
        begin
            integ_acc = sat_word(integ_acc + ((err * longint'(s.time_step)) >>> FRAC_W));
            integ_acc = clamp_to(integ_acc, integ_bound);
        end
        else
        begin
            integ_acc = 0;
        end
        total = ((kp * err) >>> FRAC_W) + ((ki * integ_acc) >>> FRAC_W)
              + ((kd * rate_err) >>> FRAC_W) + longint'(s.ff_term);
        return Q_W'(clamp_to(total, drive_bound));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [Q_W-1:0] want;
        if (!rst_n)
        begin
            kp          = 0;
            ki          = 0;
            kd          = 0;
            integ_bound = 0;
            drive_bound = 0;
            integ_acc   = 0;
            drive_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Mirror register writes; unknown indexes fall through.
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_GAIN_P:         kp = longint'($signed(cfg_data));
                    REG_GAIN_I:         ki = longint'($signed(cfg_data));
                    REG_GAIN_D:         kd = longint'($signed(cfg_data));
                    REG_INTEGRAL_LIMIT: integ_bound = longint'(cfg_data[LIM_W-1:0]);
                    REG_OUTPUT_LIMIT:   drive_bound = longint'(cfg_data[LIM_W-1:0]);
                    default:
                    begin
                    end
                endcase
            end

            // Compare each delivered drive with the oldest prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drive_q.size() == 0)
                begin
                    $error("drive: expected none, actual %0d", $signed(m_axis_tdata));
                    mismatches++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (m_axis_tdata !== want)
                    begin
                        $error("drive: expected %0d, actual %0d",
                               $signed(want), $signed(m_axis_tdata));
                        mismatches++;
                    end
                end
            end

            // Predict the drive for each accepted sample.
            if (s_axis_tvalid && s_axis_tready)
                drive_q.push_back(next_drive(sample_t'(s_axis_tdata)));

            outstanding = drive_q.size();
        end
    end

endmodule

>>> bench/tb_pid_feedforward_controller_core.sv
// Testbench top for the PID feed-forward controller: clock, reset, stimulus and verdict.
module tb_pid_feedforward_controller_core;
    import pfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [Q_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [TS_W-1:0] TS_MAX = 16'hFFFF;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_SAMPLES  = 195;
    localparam int STEADY_PHASE   = 3;
    localparam int IDLE_PCT       = 38;
    localparam int SETTLE_CYCLES  = 16;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [Q_W-1:0]   m_axis_tdata;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [Q_W-1:0]   cfg_data;
    logic             steady = 1'b0;
    int               fail_count;
    int               pending_count;

    pid_feedforward_controller_core u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pfc_drive_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (fail_count),
        .outstanding   (pending_count)
    );

    always #4 clk = ~clk;

    function automatic bit idle_now();
        return !steady && ($urandom_range(99, 0) < IDLE_PCT);
    endfunction

    // Stall the result side at random.
    always @(negedge clk)
        m_axis_tready <= !idle_now();

    // Offset a word by a random amount within +/- span.
    function automatic logic [Q_W-1:0] near(input logic [Q_W-1:0] center,
                                            input int unsigned span);
        return center + ($urandom_range(2 * span, 0) - span);
    endfunction

    function automatic logic [Q_W-1:0] pick_raw();
        case ($urandom_range(5, 0))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [Q_W-1:0] pick_gain();
        case ($urandom_range(6, 0))
            0:       return '0;
            1:       return Q_MIN;
            2:       return Q_MAX;
            3:       return $urandom;
            default: return near('0, 32'h0004_0000);
        endcase
    endfunction

    function automatic logic [Q_W-1:0] pick_bound();
        case ($urandom_range(5, 0))
            0:       return '0;
            1:       return Q_MAX;
            2:       return $urandom;
            default: return $urandom_range(32'h0010_0000, 1);
        endcase
    endfunction

    // Present one item and hold it until accepted; entered and left at a falling edge.
    task automatic send_fields(input logic [Q_W-1:0] meas, meas_rate, tgt, tgt_rate, ff,
                               input logic [TS_W-1:0] dt);
        while (idle_now())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dt, ff, tgt_rate, tgt, meas_rate, meas};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted drive has been delivered.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_count != 0);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [Q_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Load all five registers, preceded by a write to an unused index.
    task automatic set_regs(input logic [Q_W-1:0] p, i, d, ilim, olim);
        write_reg(IDX_W'(int'(REG_OUTPUT_LIMIT) + $urandom_range(3, 1)), $urandom);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_INTEGRAL_LIMIT, ilim);
        write_reg(REG_OUTPUT_LIMIT, olim);
        cfg_valid <= 1'b0;
    endtask

    // Mostly plausible loop samples, with raw and extreme words mixed in.
    task automatic send_random();
        logic [Q_W-1:0] tgt;
        logic [Q_W-1:0] tgt_rate;
        logic [TS_W-1:0] dt;
        if ($urandom_range(9, 0) < 7)
        begin
            tgt      = near('0, 32'h0064_0000);
            tgt_rate = near('0, 32'h000A_0000);
            case ($urandom_range(7, 0))
                0:       dt = '0;
                1:       dt = TS_MAX;
                default: dt = TS_W'($urandom_range(16'h0400, 1));
            endcase
            send_fields(near(tgt, 32'h0005_0000), near(tgt_rate, 32'h0002_0000),
                        tgt, tgt_rate, near('0, 32'h0001_0000), dt);
        end
        else
        begin
            case ($urandom_range(3, 0))
                0:       dt = '0;
                1:       dt = TS_MAX;
                default: dt = TS_W'($urandom_range(TS_MAX, 0));
            endcase
            send_fields(pick_raw(), pick_raw(), pick_raw(), pick_raw(), pick_raw(), dt);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers at reset: zero output bound holds the drive at zero.
        send_fields(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, TS_MAX);
        send_fields(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0);
        drain();

        // Unit P gain, fractional I and D gains, wide bounds: saturated errors and drive clamping.
        set_regs(Q_ONE, 32'h0000_8000, 32'h0000_4000, Q_MAX, Q_MAX);
        send_fields(Q_MIN, Q_MAX, Q_MAX, Q_MIN, '0, TS_MAX);
        send_fields(Q_MAX, Q_MIN, Q_MIN, Q_MAX, '0, TS_MAX);
        send_fields(Q_ONE, '0, 32'h0003_0000, 32'h0000_8000, '0, '0);
        send_fields('0, '0, 32'h0002_0000, '0, Q_MAX, 16'h0100);
        send_fields('0, '0, 32'hFFFE_0000, '0, Q_MIN, 16'h0100);
        drain();

        // Extreme gains with a tight integral bound.
        set_regs(Q_MIN, Q_MAX, Q_MIN, Q_ONE, 32'h0040_0000);
        send_fields('0, '0, 32'h0001_8000, '0, '0, 16'h8000);
        send_fields('0, '0, 32'h0001_8000, 32'h0000_0001, '0, 16'h8000);
        send_fields(Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'h0000_1000, TS_MAX);
        send_fields(32'hFFFF_0000, Q_MAX, Q_ONE, Q_MIN, '0, 16'h4000);
        drain();

        // Negative integral gain with a zero integral bound.
        set_regs(32'h0002_0000, 32'hFFFF_4000, Q_ONE, '0, Q_MAX);
        send_fields('0, '0, 32'h0005_0000, '0, '0, TS_MAX);
        send_fields('0, '0, 32'hFFF0_0000, '0, '0, 16'h2000);
        send_fields(Q_ONE, '0, Q_ONE, '0, '0, '0);
        drain();

        // Negative integral gain against a small bound.
        set_regs(32'h0002_0000, 32'hFFFF_4000, Q_ONE, 32'h0002_0000, Q_MAX);
        send_fields('0, '0, 32'h0005_0000, '0, '0, TS_MAX);
        send_fields('0, '0, 32'h0005_0000, '0, '0, '0);
        send_fields('0, '0, 32'hFFF0_0000, '0, '0, 16'h2000);
        drain();

        // Zero integral gain clears the kept integral.
        set_regs(32'h0002_0000, '0, Q_ONE, 32'h0002_0000, Q_MAX);
        send_fields('0, '0, 32'h0005_0000, '0, '0, TS_MAX);
        send_fields('0, Q_ONE, '0, '0, '0, 16'h1000);
        drain();

        // Zero output bound with live gains.
        set_regs(Q_MAX, Q_ONE, Q_MAX, Q_MAX, '0);
        send_fields(Q_MIN, '0, Q_MAX, Q_ONE, Q_MAX, TS_MAX);
        send_fields(Q_MAX, Q_ONE, Q_MIN, '0, Q_MIN, TS_MAX);
        drain();

        // Random settings, each followed by a burst of samples.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_regs(pick_gain(), pick_gain(), pick_gain(), pick_bound(), pick_bound());
            steady = (ph == STEADY_PHASE);
            for (int n = 0; n < PHASE_SAMPLES; n++)
                send_random();
            drain();
            steady = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
